[rtl/wsfr_pkg.sv]
// ----------------------------------------------------------------------------
// wsfr_pkg
// types and constants shared by the websocket frame receiver
// ----------------------------------------------------------------------------
package wsfr_pkg;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_KEY,
        PH_PAYLOAD,
        PH_CLOSED
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_PONG    = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    localparam logic       ERR_MASK_MISSING = 1'b0;
    localparam logic       ERR_TOO_LONG     = 1'b1;

    localparam logic       REG_CLIENT_MODE  = 1'b0;
    localparam logic       REG_MAX_SIZE     = 1'b1;

    localparam logic [6:0] LEN16_CODE       = 7'd126;
    localparam logic [6:0] LEN64_CODE       = 7'd127;
    localparam logic [3:0] EXT16_BYTES      = 4'd2;
    localparam logic [3:0] EXT64_BYTES      = 4'd8;
    localparam logic [3:0] KEY_BYTES        = 4'd4;

    localparam logic [3:0] OP_TEXT          = 4'd1;
    localparam logic [3:0] OP_BINARY        = 4'd2;
    localparam logic [3:0] OP_LAST_DATA     = 4'd2;
    localparam logic [3:0] OP_PING          = 4'd9;

    localparam logic [31:0] DEFAULT_MAX_SIZE = 32'd33554432;

    typedef struct packed {
        logic        client_mode;
        logic [31:0] max_message_size;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [3:0]  message_opcode;
        logic        last_of_message;
        logic        error_code;
    } result_t;

endpackage

[rtl/wsfr_if.sv]
// ----------------------------------------------------------------------------
// wsfr channel interfaces
// valid/ready channels for received bytes, results and register writes
// ----------------------------------------------------------------------------
interface wsfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [3:0] message_opcode;
    logic       last_of_message;
    logic       error_code;

    modport source (output valid, output kind, output payload_byte, output message_opcode,
                    output last_of_message, output error_code, input ready);
    modport sink   (input valid, input kind, input payload_byte, input message_opcode,
                    input last_of_message, input error_code, output ready);
endinterface

interface wsfr_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/websocket_frame_receiver.sv]
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// deframes a received websocket byte stream into unmasked payload results
// a byte passes the input register, the parser and then the result register
// throughput: one byte per cycle while results are taken, set by the single-step parser between the registers
// the result register lets a new byte step in as a waiting result is taken
// reset: parser returns to the first header byte, valid flags clear, config registers take their defaults
// ----------------------------------------------------------------------------
module websocket_frame_receiver (
    input  logic           clk,
    input  logic           rst_n,
    wsfr_byte_if.sink      rx,
    wsfr_result_if.source  res,
    wsfr_cfg_if.sink       cfg
);

    wsfr_pkg::cfg_t    cfg_q;
    wsfr_pkg::result_t step_res;
    wsfr_pkg::result_t out_res_reg;
    logic              step_valid;
    logic              in_vld_reg;
    logic [7:0]        in_byte_reg;
    logic              out_vld_reg;
    logic              advance;
    logic              step_en;

    assign advance  = !out_vld_reg || res.ready;
    assign rx.ready = !in_vld_reg || advance;
    assign step_en  = in_vld_reg && advance;

    wsfr_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    wsfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .byte_in   (in_byte_reg),
        .cfg_q     (cfg_q),
        .res_valid (step_valid),
        .res       (step_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_vld_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= step_en && step_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && step_valid)
        begin
            out_res_reg <= step_res;
        end
    end

    assign res.valid           = out_vld_reg;
    assign res.kind            = out_res_reg.kind;
    assign res.payload_byte    = out_res_reg.payload_byte;
    assign res.message_opcode  = out_res_reg.message_opcode;
    assign res.last_of_message = out_res_reg.last_of_message;
    assign res.error_code      = out_res_reg.error_code;

endmodule

[rtl/wsfr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// wsfr_cfg_regs
// configuration registers, written through the register write channel
// ----------------------------------------------------------------------------
module wsfr_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    wsfr_cfg_if.sink       cfg,
    output wsfr_pkg::cfg_t cfg_q
);

    logic        client_mode_reg;
    logic [31:0] max_size_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_mode_reg <= 1'b0;
            max_size_reg    <= wsfr_pkg::DEFAULT_MAX_SIZE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                wsfr_pkg::REG_CLIENT_MODE: client_mode_reg <= cfg.data[0];
                wsfr_pkg::REG_MAX_SIZE:    max_size_reg    <= cfg.data;
                default:                   ;
            endcase
        end
    end

    assign cfg_q.client_mode      = client_mode_reg;
    assign cfg_q.max_message_size = max_size_reg;

endmodule

[rtl/wsfr_parser.sv]
// ----------------------------------------------------------------------------
// wsfr_parser
// frame header parser, payload unmasking and message tracking, one byte a step
// ----------------------------------------------------------------------------
module wsfr_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        byte_in,
    input  wsfr_pkg::cfg_t    cfg_q,
    output logic              res_valid,
    output wsfr_pkg::result_t res
);

    wsfr_pkg::phase_t phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [3:0]  hdr_count_reg, hdr_count_next;
    logic [63:0] frame_len_reg, frame_len_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [63:0] remaining_reg, remaining_next;
    logic [1:0]  key_pos_reg, key_pos_next;
    logic [31:0] msg_len_reg, msg_len_next;
    logic [3:0]  asm_op_reg, asm_op_next;

    logic        is_data;
    logic [6:0]  len7;
    logic [63:0] len_val;
    logic        masked_eff;
    logic        do_len;
    logic        do_begin;
    logic        too_long;
    logic [32:0] len_sum;
    logic [3:0]  cnt_inc;
    logic [3:0]  cnt_dec;
    logic [7:0]  key_byte;
    logic        last_byte;
    logic        fin_last;

    assign is_data = (opcode_reg <= wsfr_pkg::OP_LAST_DATA);
    assign len7    = byte_in[6:0];
    assign cnt_inc = hdr_count_reg + 4'd1;
    assign cnt_dec = hdr_count_reg - 4'd1;

    always_comb
    begin
        case (key_pos_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        fin_next       = fin_reg;
        opcode_next    = opcode_reg;
        masked_next    = masked_reg;
        hdr_count_next = hdr_count_reg;
        frame_len_next = frame_len_reg;
        mask_key_next  = mask_key_reg;
        remaining_next = remaining_reg;
        key_pos_next   = key_pos_reg;
        msg_len_next   = msg_len_reg;
        asm_op_next    = asm_op_reg;

        res_valid          = 1'b0;
        res.kind           = wsfr_pkg::KIND_PAYLOAD;
        res.payload_byte   = 8'd0;
        res.message_opcode = asm_op_reg;
        res.last_of_message = 1'b0;
        res.error_code     = 1'b0;

        len_val    = frame_len_reg;
        masked_eff = masked_reg;
        do_len     = 1'b0;
        do_begin   = 1'b0;
        last_byte  = (remaining_reg == 64'd1);
        fin_last   = 1'b0;

        case (phase_reg)
            wsfr_pkg::PH_HDR0:
            begin
                fin_next    = byte_in[7];
                opcode_next = byte_in[3:0];
                if (asm_op_reg == 4'd0 && (byte_in[3:0] == wsfr_pkg::OP_TEXT ||
                                           byte_in[3:0] == wsfr_pkg::OP_BINARY))
                begin
                    asm_op_next = byte_in[3:0];
                end
                phase_next = wsfr_pkg::PH_HDR1;
            end
            wsfr_pkg::PH_HDR1:
            begin
                masked_next = byte_in[7];
                masked_eff  = byte_in[7];
                if (opcode_reg == wsfr_pkg::OP_PING)
                begin
                    res_valid = 1'b1;
                    res.kind  = wsfr_pkg::KIND_PONG;
                end
                if (is_data && !cfg_q.client_mode && !byte_in[7])
                begin
                    phase_next     = wsfr_pkg::PH_CLOSED;
                    res_valid      = 1'b1;
                    res.kind       = wsfr_pkg::KIND_ERROR;
                    res.error_code = wsfr_pkg::ERR_MASK_MISSING;
                end
                else
                begin
                    hdr_count_next = 4'd0;
                    if (len7 inside {wsfr_pkg::LEN16_CODE, wsfr_pkg::LEN64_CODE})
                    begin
                        frame_len_next = 64'd0;
                        hdr_count_next = (len7 == wsfr_pkg::LEN16_CODE) ?
                                         wsfr_pkg::EXT16_BYTES : wsfr_pkg::EXT64_BYTES;
                        phase_next     = wsfr_pkg::PH_EXT;
                    end
                    else
                    begin
                        len_val        = {57'd0, len7};
                        frame_len_next = len_val;
                        do_len         = 1'b1;
                    end
                end
            end
            wsfr_pkg::PH_EXT:
            begin
                len_val        = {frame_len_reg[55:0], byte_in};
                frame_len_next = len_val;
                hdr_count_next = cnt_dec;
                if (cnt_dec == 4'd0)
                begin
                    do_len = 1'b1;
                end
            end
            wsfr_pkg::PH_KEY:
            begin
                mask_key_next = {mask_key_reg[23:0], byte_in};
                if (cnt_inc >= wsfr_pkg::KEY_BYTES)
                begin
                    hdr_count_next = 4'd0;
                    do_begin       = 1'b1;
                end
                else
                begin
                    hdr_count_next = cnt_inc;
                end
            end
            wsfr_pkg::PH_PAYLOAD:
            begin
                remaining_next = remaining_reg - 64'd1;
                key_pos_next   = key_pos_reg + 2'd1;
                if (is_data)
                begin
                    fin_last            = last_byte && fin_reg;
                    res_valid           = 1'b1;
                    res.kind            = wsfr_pkg::KIND_PAYLOAD;
                    res.payload_byte    = byte_in ^ key_byte;
                    res.last_of_message = fin_last;
                    if (fin_last)
                    begin
                        msg_len_next = 32'd0;
                        asm_op_next  = 4'd0;
                    end
                end
                if (last_byte)
                begin
                    phase_next = wsfr_pkg::PH_HDR0;
                end
            end
            wsfr_pkg::PH_CLOSED:
            begin
                phase_next = wsfr_pkg::PH_CLOSED;
            end
            default:
            begin
                phase_next = wsfr_pkg::PH_CLOSED;
            end
        endcase

        // length complete: size check for data frames, then key, payload or next header
        len_sum  = {1'b0, msg_len_reg} + {1'b0, len_val[31:0]};
        too_long = (|len_val[63:32]) || (len_sum >= {1'b0, cfg_q.max_message_size});
        if (do_len)
        begin
            if (is_data && too_long)
            begin
                phase_next     = wsfr_pkg::PH_CLOSED;
                res_valid      = 1'b1;
                res.kind       = wsfr_pkg::KIND_ERROR;
                res.error_code = wsfr_pkg::ERR_TOO_LONG;
            end
            else
            begin
                if (is_data)
                begin
                    msg_len_next = len_sum[31:0];
                end
                mask_key_next = 32'd0;
                if (masked_eff)
                begin
                    phase_next     = wsfr_pkg::PH_KEY;
                    hdr_count_next = 4'd0;
                end
                else
                begin
                    do_begin = 1'b1;
                end
            end
        end

        if (do_begin)
        begin
            remaining_next = len_val;
            key_pos_next   = 2'd0;
            if (len_val == 64'd0)
            begin
                phase_next = wsfr_pkg::PH_HDR0;
                if (is_data && fin_reg)
                begin
                    res_valid           = 1'b1;
                    res.kind            = wsfr_pkg::KIND_END;
                    res.last_of_message = 1'b1;
                    msg_len_next        = 32'd0;
                    asm_op_next         = 4'd0;
                end
            end
            else
            begin
                phase_next = wsfr_pkg::PH_PAYLOAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wsfr_pkg::PH_HDR0;
            fin_reg       <= 1'b0;
            opcode_reg    <= 4'd0;
            masked_reg    <= 1'b0;
            hdr_count_reg <= 4'd0;
            frame_len_reg <= 64'd0;
            mask_key_reg  <= 32'd0;
            remaining_reg <= 64'd0;
            key_pos_reg   <= 2'd0;
            msg_len_reg   <= 32'd0;
            asm_op_reg    <= 4'd0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            fin_reg       <= fin_next;
            opcode_reg    <= opcode_next;
            masked_reg    <= masked_next;
            hdr_count_reg <= hdr_count_next;
            frame_len_reg <= frame_len_next;
            mask_key_reg  <= mask_key_next;
            remaining_reg <= remaining_next;
            key_pos_reg   <= key_pos_next;
            msg_len_reg   <= msg_len_next;
            asm_op_reg    <= asm_op_next;
        end
    end

endmodule
